>>> rtl/sfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants and CRC helpers for the serial frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 8;

  localparam logic [CfgIdxW-1:0] CFG_START_BYTE = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_DROP_REPEAT = 1'd1;

  localparam logic [ByteW-1:0] START_BYTE_RST = 8'h05;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [StatusW-1:0] STAT_GOOD   = 2'd0;
  localparam logic [StatusW-1:0] STAT_CRC    = 2'd1;
  localparam logic [StatusW-1:0] STAT_REPEAT = 2'd2;

  localparam logic [ByteW-1:0] CRC8_INIT  = 8'hFF;
  localparam logic [ByteW-1:0] CRC8_POLY  = 8'h8C;
  localparam logic [WordW-1:0] CRC16_INIT = 16'hFFFF;
  localparam logic [WordW-1:0] CRC16_POLY = 16'h8408;
  localparam logic [ByteW-1:0] SEQ_RST    = 8'hFF;

  function automatic logic [ByteW-1:0] crc8_next(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [WordW-1:0] crc16_next(input logic [WordW-1:0] crc,
                                                  input logic [ByteW-1:0] b);
    logic [WordW-1:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/serial_frame_receiver_crc_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc_top
// Frame receiver: header CRC-8 check, data pass-through, CRC-16 report.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  rx       in   rx_valid_i/rx_ready_o  rx_byte_i
//  res      out  res_valid_o/res_ready_i result_kind_o, payload_byte_o,
//                                       frame_command_o, frame_length_o,
//                                       frame_sequence_o, frame_status_o
//  cfg      in   cfg_we_i               cfg_index_i, cfg_data_i
//
//  One byte per cycle while rx_ready_o is high; the frame state and CRCs update in the accept cycle.
//  A result appears in the output register in the cycle after its byte is accepted.
//  A new byte is taken while the output register empties in the same cycle.
//  rx_ready_o drops only while a result waits and res_ready_i is low.
//  Reset returns the receiver to start-byte hunting with default config.
// ----------------------------------------------------------------------------
module serial_frame_receiver_crc_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sfr_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [sfr_pkg::CfgW-1:0]       cfg_data_i,
  input  logic                           rx_valid_i,
  output logic                           rx_ready_o,
  input  logic [sfr_pkg::ByteW-1:0]      rx_byte_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output logic                           result_kind_o,
  output logic [sfr_pkg::ByteW-1:0]      payload_byte_o,
  output logic [sfr_pkg::WordW-1:0]      frame_command_o,
  output logic [sfr_pkg::WordW-1:0]      frame_length_o,
  output logic [sfr_pkg::ByteW-1:0]      frame_sequence_o,
  output logic [sfr_pkg::StatusW-1:0]    frame_status_o
);
  import sfr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_SEQ  = 3'd2,
    PH_HCRC = 3'd3,
    PH_CMD  = 3'd4,
    PH_DATA = 3'd5,
    PH_TCRC = 3'd6
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [WordW-1:0]   cnt_q, cnt_d, cnt_inc;
  logic [WordW-1:0]   len_q, len_d;
  logic [WordW-1:0]   cmd_q, cmd_d;
  logic [ByteW-1:0]   hcrc_q, hcrc_d;
  logic [WordW-1:0]   fcrc_q, fcrc_d;
  logic [ByteW-1:0]   rcrc_lo_q, rcrc_lo_d;
  logic [ByteW-1:0]   last_seq_q, last_seq_d;
  logic [ByteW-1:0]   cur_seq_q, cur_seq_d;
  logic               rep_q, rep_d;
  logic [ByteW-1:0]   start_q;
  logic               drop_q;

  logic               res_valid_q, res_valid_d;
  logic               kind_q, kind_d;
  logic [ByteW-1:0]   pay_q, pay_d;
  logic [WordW-1:0]   ocmd_q, ocmd_d;
  logic [WordW-1:0]   olen_q, olen_d;
  logic [ByteW-1:0]   oseq_q, oseq_d;
  logic [StatusW-1:0] ostat_q, ostat_d;

  logic               accept;
  logic               emit;
  logic [ByteW-1:0]   b;

  assign rx_ready_o = !res_valid_q || res_ready_i;
  assign accept     = rx_valid_i && rx_ready_o;
  assign b          = rx_byte_i;
  assign cnt_inc    = cnt_q + 16'd1;

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    len_d      = len_q;
    cmd_d      = cmd_q;
    hcrc_d     = hcrc_q;
    fcrc_d     = fcrc_q;
    rcrc_lo_d  = rcrc_lo_q;
    last_seq_d = last_seq_q;
    cur_seq_d  = cur_seq_q;
    rep_d      = rep_q;
    emit       = 1'b0;
    kind_d     = kind_q;
    pay_d      = pay_q;
    ocmd_d     = ocmd_q;
    olen_d     = olen_q;
    oseq_d     = oseq_q;
    ostat_d    = ostat_q;
    if (accept) begin
      unique case (phase_q)
        PH_LEN: begin
          hcrc_d = crc8_next(hcrc_q, b);
          fcrc_d = crc16_next(fcrc_q, b);
          if (cnt_q == '0) begin
            len_d = {len_q[15:8], b};
            cnt_d = 16'd1;
          end else begin
            len_d   = {b, len_q[7:0]};
            cnt_d   = '0;
            phase_d = PH_SEQ;
          end
        end
        PH_SEQ: begin
          hcrc_d     = crc8_next(hcrc_q, b);
          fcrc_d     = crc16_next(fcrc_q, b);
          cur_seq_d  = b;
          if (drop_q && (b == last_seq_q)) begin
            rep_d = 1'b1;
          end
          last_seq_d = b;
          phase_d    = PH_HCRC;
        end
        PH_HCRC: begin
          if (b == hcrc_q) begin
            fcrc_d  = crc16_next(fcrc_q, b);
            cnt_d   = '0;
            phase_d = PH_CMD;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_CMD: begin
          fcrc_d = crc16_next(fcrc_q, b);
          if (cnt_q == '0) begin
            cmd_d = {cmd_q[15:8], b};
            cnt_d = 16'd1;
          end else begin
            cmd_d   = {b, cmd_q[7:0]};
            cnt_d   = '0;
            phase_d = (len_q == '0) ? PH_TCRC : PH_DATA;
          end
        end
        PH_DATA: begin
          fcrc_d = crc16_next(fcrc_q, b);
          if (cnt_inc >= len_q) begin
            cnt_d   = '0;
            phase_d = PH_TCRC;
          end else begin
            cnt_d = cnt_inc;
          end
          emit    = 1'b1;
          kind_d  = KIND_DATA;
          pay_d   = b;
          ocmd_d  = cmd_q;
          olen_d  = len_q;
          oseq_d  = cur_seq_q;
          ostat_d = STAT_GOOD;
        end
        PH_TCRC: begin
          if (cnt_q == '0) begin
            rcrc_lo_d = b;
            cnt_d     = 16'd1;
          end else begin
            cnt_d   = '0;
            phase_d = PH_HUNT;
            emit    = 1'b1;
            kind_d  = KIND_REPORT;
            pay_d   = '0;
            ocmd_d  = cmd_q;
            olen_d  = len_q;
            oseq_d  = cur_seq_q;
            if ({b, rcrc_lo_q} != fcrc_q) begin
              ostat_d = STAT_CRC;
            end else if (rep_q) begin
              ostat_d = STAT_REPEAT;
            end else begin
              ostat_d = STAT_GOOD;
            end
          end
        end
        default: begin
          phase_d = PH_HUNT;
          if (b == start_q) begin
            hcrc_d    = crc8_next(CRC8_INIT, b);
            fcrc_d    = crc16_next(CRC16_INIT, b);
            cnt_d     = '0;
            rcrc_lo_d = '0;
            rep_d     = 1'b0;
            phase_d   = PH_LEN;
          end
        end
      endcase
    end
    if (emit) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      cnt_q       <= '0;
      len_q       <= '0;
      cmd_q       <= '0;
      hcrc_q      <= CRC8_INIT;
      fcrc_q      <= CRC16_INIT;
      rcrc_lo_q   <= '0;
      last_seq_q  <= SEQ_RST;
      cur_seq_q   <= '0;
      rep_q       <= 1'b0;
      start_q     <= START_BYTE_RST;
      drop_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      cmd_q       <= cmd_d;
      hcrc_q      <= hcrc_d;
      fcrc_q      <= fcrc_d;
      rcrc_lo_q   <= rcrc_lo_d;
      last_seq_q  <= last_seq_d;
      cur_seq_q   <= cur_seq_d;
      rep_q       <= rep_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_START_BYTE:  start_q <= cfg_data_i;
          CFG_DROP_REPEAT: drop_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    pay_q   <= pay_d;
    ocmd_q  <= ocmd_d;
    olen_q  <= olen_d;
    oseq_q  <= oseq_d;
    ostat_q <= ostat_d;
  end

  assign res_valid_o      = res_valid_q;
  assign result_kind_o    = kind_q;
  assign payload_byte_o   = pay_q;
  assign frame_command_o  = ocmd_q;
  assign frame_length_o   = olen_q;
  assign frame_sequence_o = oseq_q;
  assign frame_status_o   = ostat_q;

endmodule

>>> rtl/sfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks for the serial frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module sfr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        rx_valid_i,
  input logic                        rx_ready_o,
  input logic                        res_valid_o,
  input logic                        res_ready_i,
  input logic                        result_kind_o,
  input logic [sfr_pkg::ByteW-1:0]   payload_byte_o,
  input logic [sfr_pkg::StatusW-1:0] frame_status_o
);
  import sfr_pkg::*;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(payload_byte_o)
      && $stable(frame_status_o) && $stable(result_kind_o))
    else $error("result request changed while stalled");

  a_res_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_o) |-> $past(rx_valid_i && rx_ready_o))
    else $error("result request without an accepted byte");

  a_data_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (result_kind_o == KIND_DATA) |-> frame_status_o == STAT_GOOD)
    else $error("data request carries a status");

  a_report_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (result_kind_o == KIND_REPORT) |->
      (payload_byte_o == '0) && (frame_status_o != 2'd3))
    else $error("malformed frame report");

endmodule

bind serial_frame_receiver_crc_top sfr_checker u_sfr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rx_valid_i     (rx_valid_i),
  .rx_ready_o     (rx_ready_o),
  .res_valid_o    (res_valid_o),
  .res_ready_i    (res_ready_i),
  .result_kind_o  (result_kind_o),
  .payload_byte_o (payload_byte_o),
  .frame_status_o (frame_status_o)
);
